// ----- rtl/core/aasp_pkg.sv -----
// Shared constants and the quarter-sine table builder for the averaging block.
`timescale 1ns / 1ps

package aasp_pkg;

   localparam int SAMPLE_W       = 12;
   localparam int LEVEL_W        = 7;
   localparam int CMP_W          = 13;
   localparam int ENTRY_W        = 16;
   localparam int ROM_SIZE       = 101;
   localparam int LEVEL_MAX      = 100;
   localparam int LEVEL_SCALE    = 100;
   localparam int SAMPLE_MAX     = 4095;

   localparam int BLOCK_LEN_DEF  = 20;
   localparam int TIME_BASE_DEF  = 5000;
   localparam int FULL_SCALE_DEF = 4095;

   localparam longint unsigned ANGLE_NUM = 64'd314159;
   localparam longint unsigned ANGLE_DEN = 64'd20000000;
   localparam int unsigned TAYLOR_TERMS  = 40;

   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // Table entry floor(time_base * sin(angle)), evaluated in Q62 fixed point.
   function automatic logic [ENTRY_W-1:0] sine_entry(int unsigned time_base,
                                                     int unsigned idx);
      logic [63:0] one_q;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] n;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] e;
      int unsigned k;
      one_q = 64'd1 << 62;
      q     = one_q / ANGLE_DEN;
      r     = one_q % ANGLE_DEN;
      n     = ANGLE_NUM * 64'(idx);
      x     = n * q + (n * r) / ANGLE_DEN;
      x2    = mul_q62(x, x);
      sum   = x;
      term  = x;
      for (k = 1; k < TAYLOR_TERMS; k++) begin
         if (term != 64'd0) begin
            term = mul_q62(term, x2) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      e = mul_q62(64'(time_base), sum);
      return e[ENTRY_W-1:0];
   endfunction

endpackage

// ----- rtl/core/adc_average_to_sine_pwm_duty_top.sv -----
// Top level: boxcar average of converter samples and quarter-sine compare values.
//
// Usage: samples enter on the req_ channel, one per transfer. Every BLOCK_LEN-th
// sample closes a block; the block's average, scaled to 0..100, addresses a
// quarter-sine table and one result leaves on the rsp_ channel with the level
// and three compare values. The other samples produce no result.
// Throughput is one sample per cycle while req_stall is low. After the transfer
// of the sample that closes its block, the result passes through a register
// for the block sum loaded at that transfer, then a reciprocal multiply, a
// back-multiply, a correction and saturation step, and the table read into
// the output register. When the receiver stalls, the output register holds its
// result and the pipeline behind it fills; samples are still taken until the
// first pipeline stage is occupied and cannot advance, and then req_stall is
// raised. Reset clears the running sum, the sample count and all valid flags.
`timescale 1ns / 1ps

module adc_average_to_sine_pwm_duty_top
   import aasp_pkg::*;
#(
   parameter int BLOCK_LEN  = BLOCK_LEN_DEF,
   parameter int TIME_BASE  = TIME_BASE_DEF,
   parameter int FULL_SCALE = FULL_SCALE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [LEVEL_W-1:0]  rsp_level_index,
   output logic [CMP_W-1:0]    rsp_compare_inverted,
   output logic [CMP_W-1:0]    rsp_compare_direct,
   output logic [CMP_W-1:0]    rsp_compare_folded
);

   localparam int SUM_W   = $clog2(BLOCK_LEN * SAMPLE_MAX + 1);
   localparam int CNT_W   = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
   localparam int DIVISOR = FULL_SCALE * BLOCK_LEN;
   localparam int NUM_W   = $clog2(LEVEL_SCALE * BLOCK_LEN * SAMPLE_MAX + 1);
   localparam int SHIFT   = SUM_W;
   localparam longint unsigned RECIP = (64'(LEVEL_SCALE) << SHIFT) / 64'(DIVISOR);
   localparam int Q_W     = $clog2((LEVEL_SCALE * SAMPLE_MAX) / FULL_SCALE + 2);
   localparam int PROD_W  = SHIFT + Q_W;

   logic [ENTRY_W-1:0] sine_rom [ROM_SIZE];

   for (genvar i = 0; i < ROM_SIZE; i++) begin : g_rom
      assign sine_rom[i] = sine_entry(TIME_BASE, i);
   end

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [NUM_W-1:0]   t100_ff, t100_in, t100b_ff;
   logic [Q_W-1:0]     q0_ff, q0_in;
   logic [NUM_W-1:0]   qd_ff, qd_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic [CMP_W-1:0]   rsp_inv_ff, rsp_inv_in, rsp_dir_ff, rsp_dir_in;
   logic [CMP_W-1:0]   rsp_fold_ff, rsp_fold_in;

   logic               rsp_free, rdy1, rdy2, rdy3, rdy4, accept, last;
   logic [SUM_W-1:0]   total;
   logic [NUM_W-1:0]   rem;
   logic [Q_W-1:0]     q;
   logic [ENTRY_W-1:0] entry;
   logic [ENTRY_W:0]   twice, tb_ext;
   logic [ENTRY_W-1:0] inverted;
   logic [ENTRY_W:0]   folded;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rdy4      = !v4_ff || rsp_free;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;
   assign accept    = req_valid && rdy1;
   assign last      = count_ff == CNT_W'(BLOCK_LEN - 1);

   always_comb begin
      total    = sum_ff + SUM_W'(req_sample);
      sum_in   = sum_ff;
      count_in = count_ff;
      total_in = total_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
            total_in = total;
         end else begin
            sum_in   = total;
            count_in = count_ff + CNT_W'(1);
         end
      end

      v1_in   = rdy1 ? (accept && last) : v1_ff;
      v2_in   = rdy2 ? v1_ff : v2_ff;
      v3_in   = rdy3 ? v2_ff : v3_ff;
      v4_in   = rdy4 ? v3_ff : v4_ff;

      prod_in = PROD_W'(total_ff) * PROD_W'(RECIP);
      t100_in = NUM_W'(total_ff) * NUM_W'(LEVEL_SCALE);

      q0_in   = prod_ff[PROD_W-1:SHIFT];
      qd_in   = NUM_W'(q0_in) * NUM_W'(DIVISOR);

      rem     = t100b_ff - qd_ff;
      q       = q0_ff + Q_W'(rem >= NUM_W'(DIVISOR));
      if (q > Q_W'(LEVEL_MAX)) begin
         level_in = LEVEL_W'(LEVEL_MAX);
      end else begin
         level_in = q[LEVEL_W-1:0];
      end

      entry       = sine_rom[level_ff];
      inverted    = ENTRY_W'(TIME_BASE) - entry;
      twice       = {entry, 1'b0};
      tb_ext      = (ENTRY_W + 1)'(TIME_BASE);
      folded      = (twice > tb_ext) ? (twice - tb_ext) : (tb_ext - twice);
      rsp_inv_in  = inverted[CMP_W-1:0];
      rsp_dir_in  = entry[CMP_W-1:0];
      rsp_fold_in = folded[CMP_W-1:0];

      rsp_valid_in = rsp_free ? v4_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      if (rdy2) begin
         prod_ff <= prod_in;
         t100_ff <= t100_in;
      end
      if (rdy3) begin
         q0_ff    <= q0_in;
         qd_ff    <= qd_in;
         t100b_ff <= t100_ff;
      end
      if (rdy4) begin
         level_ff <= level_in;
      end
      if (rsp_free && v4_ff) begin
         rsp_level_ff <= level_ff;
         rsp_inv_ff   <= rsp_inv_in;
         rsp_dir_ff   <= rsp_dir_in;
         rsp_fold_ff  <= rsp_fold_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_level_index      = rsp_level_ff;
   assign rsp_compare_inverted = rsp_inv_ff;
   assign rsp_compare_direct   = rsp_dir_ff;
   assign rsp_compare_folded   = rsp_fold_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(count_ff) < (CNT_W + 1)'(BLOCK_LEN))
      else $error("sample count passed the block length");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("input stalled with an empty first stage");

   a_single_correction: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ((NUM_W + 1)'(rem) < (NUM_W + 1)'(2 * DIVISOR)))
      else $error("reciprocal estimate off by more than one");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= LEVEL_W'(LEVEL_MAX)))
      else $error("level index above table range");

   a_compare_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (CMP_W'(rsp_inv_ff + rsp_dir_ff) == CMP_W'(TIME_BASE)))
      else $error("inverted and direct compare values do not sum to the period");
`endif

endmodule
